FILE: design/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg: shared types and constants of the Exp-Golomb syntax decoder
// Element kind codes, classified work kinds, status codes and the intra
// coded block pattern mapping table.
// ----------------------------------------------------------------------------
package egsd_pkg;

   // Element kind as requested on the input channel.
   typedef enum logic [2:0] {
      FUNC_UE    = 3'd0,
      FUNC_SE    = 3'd1,
      FUNC_FIXED = 3'd2,
      FUNC_PEEK  = 3'd3,
      FUNC_ME    = 3'd4
   } func_type;

   // Work that the back end carries out for one word.
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_UE,
      KIND_SE,
      KIND_FIXED,
      KIND_ME
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_LONG_PREFIX = 2'd1,
      STATUS_BAD_INDEX  = 2'd2
   } status_type;

   localparam int PREFIX_BITS = 32;
   localparam int VALUE_BITS  = 33;
   localparam int RAW_BITS    = 32;
   localparam int LEN_BITS    = 6;
   localparam int CBP_ENTRIES = 48;

   // Classification handed from the front end to the back end.
   typedef struct packed {
      kind_type             kind;
      logic [LEN_BITS-1:0]  shift_len;
      logic [LEN_BITS-1:0]  bits_used;
      status_type           status;
   } ctl_type;

   localparam logic [5:0] CBP_INTRA_MAP [CBP_ENTRIES] = '{
      6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
      6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
      6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
      6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
      6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
   };

endpackage

FILE: design/egsd_req_if.sv
// ----------------------------------------------------------------------------
// egsd_req_if: request channel of the Exp-Golomb syntax decoder
// Carries one element request (kind, field length, stream window) per word.
// ----------------------------------------------------------------------------
interface egsd_req_if #(
   parameter int WINDOW_BITS = 64
);
   logic                   valid;
   logic                   ready;
   logic [2:0]             func;
   logic [5:0]             field_length;
   logic [WINDOW_BITS-1:0] stream_window;

   modport source (output valid, output func, output field_length,
                   output stream_window, input ready);
   modport sink   (input valid, input func, input field_length,
                   input stream_window, output ready);
endinterface

FILE: design/egsd_rsp_if.sv
// ----------------------------------------------------------------------------
// egsd_rsp_if: response channel of the Exp-Golomb syntax decoder
// Carries one decoded element (value, bits consumed, status) per word.
// ----------------------------------------------------------------------------
interface egsd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [32:0] element_value;
   logic [5:0]         bits_used;
   logic [1:0]         status;

   modport source (output valid, output element_value, output bits_used,
                   output status, input ready);
   modport sink   (input valid, input element_value, input bits_used,
                   input status, output ready);
endinterface

FILE: design/egsd_front.sv
// ----------------------------------------------------------------------------
// egsd_front: request classification
// Counts the leading zeros of the window, saturates the fixed field length
// and decides the kind of work, the extraction length and the bits consumed.
// ----------------------------------------------------------------------------
module egsd_front #(
   parameter int WINDOW_BITS    = 64,
   parameter int MAX_FIXED_BITS = 32
) (
   egsd_req_if.sink                    req_if,
   input  logic                        q_ready,
   output logic                        q_valid,
   output egsd_pkg::ctl_type           q_ctl,
   output logic [WINDOW_BITS-1:0]      q_window
);

   logic [egsd_pkg::PREFIX_BITS-1:0] prefix;
   logic [4:0]                       zeros;
   logic                             prefix_empty;
   logic [egsd_pkg::LEN_BITS-1:0]    code_len;
   logic [egsd_pkg::LEN_BITS-1:0]    fixed_len;
   egsd_pkg::ctl_type                ctl;

   assign prefix       = req_if.stream_window[WINDOW_BITS-1 -: egsd_pkg::PREFIX_BITS];
   assign prefix_empty = (prefix == '0);

   // Priority encoder: the most significant set bit sets the zero count.
   always_comb begin
      zeros = '0;
      for (int i = 0; i < egsd_pkg::PREFIX_BITS; i++) begin
         if (prefix[i]) begin
            zeros = 5'(egsd_pkg::PREFIX_BITS - 1 - i);
         end
      end
   end

   assign code_len  = {zeros, 1'b1};
   assign fixed_len = (req_if.field_length > egsd_pkg::LEN_BITS'(MAX_FIXED_BITS))
                      ? egsd_pkg::LEN_BITS'(MAX_FIXED_BITS) : req_if.field_length;

   always_comb begin
      ctl.kind      = egsd_pkg::KIND_NONE;
      ctl.shift_len = '0;
      ctl.bits_used = '0;
      ctl.status    = egsd_pkg::STATUS_OK;
      case (req_if.func)
         egsd_pkg::FUNC_UE, egsd_pkg::FUNC_SE, egsd_pkg::FUNC_ME: begin
            if (prefix_empty) begin
               ctl.status = egsd_pkg::STATUS_LONG_PREFIX;
            end else begin
               ctl.kind      = (req_if.func == egsd_pkg::FUNC_UE) ? egsd_pkg::KIND_UE :
                               (req_if.func == egsd_pkg::FUNC_SE) ? egsd_pkg::KIND_SE :
                                                                    egsd_pkg::KIND_ME;
               ctl.shift_len = code_len;
               ctl.bits_used = code_len;
            end
         end
         egsd_pkg::FUNC_FIXED: begin
            ctl.kind      = egsd_pkg::KIND_FIXED;
            ctl.shift_len = fixed_len;
            ctl.bits_used = fixed_len;
         end
         egsd_pkg::FUNC_PEEK: begin
            ctl.kind      = egsd_pkg::KIND_FIXED;
            ctl.shift_len = fixed_len;
         end
         default: begin
            ctl.kind = egsd_pkg::KIND_NONE;
         end
      endcase
   end

   assign q_valid      = req_if.valid;
   assign q_ctl        = ctl;
   assign q_window     = req_if.stream_window;
   assign req_if.ready = q_ready;

endmodule

FILE: design/egsd_queue.sv
// ----------------------------------------------------------------------------
// egsd_queue: two-entry queue between front and back end
// Registered storage with valid/ready on both sides; full rate when the
// back end drains every cycle.
// ----------------------------------------------------------------------------
module egsd_queue #(
   parameter int WIDTH = 80
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff,  count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/egsd_back.sv
// ----------------------------------------------------------------------------
// egsd_back: element extraction and value mapping
// Extracts the leading bits of the window, forms the unsigned, signed,
// fixed or mapped value and holds the result in the output register.
// ----------------------------------------------------------------------------
module egsd_back #(
   parameter int WINDOW_BITS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  egsd_pkg::ctl_type      q_ctl,
   input  logic [WINDOW_BITS-1:0] q_window,
   egsd_rsp_if.source             rsp_if
);

   localparam int SHIFT_BITS = $clog2(WINDOW_BITS + 1);

   logic [SHIFT_BITS-1:0]          shift_amt;
   logic [WINDOW_BITS-1:0]         shifted;
   logic [egsd_pkg::RAW_BITS-1:0]  raw;
   logic [egsd_pkg::VALUE_BITS-1:0] half;
   logic [5:0]                     cbp_index;
   logic                           cbp_hit;
   logic [egsd_pkg::VALUE_BITS-1:0] value_in;
   egsd_pkg::status_type           status_in;
   logic                           load;

   logic                            valid_ff;
   logic [egsd_pkg::VALUE_BITS-1:0] value_ff;
   logic [egsd_pkg::LEN_BITS-1:0]   used_ff;
   egsd_pkg::status_type            status_ff;

   // A zero extraction length shifts the whole window out and leaves zero.
   assign shift_amt = SHIFT_BITS'(WINDOW_BITS) - SHIFT_BITS'(q_ctl.shift_len);
   assign shifted   = q_window >> shift_amt;
   assign raw       = shifted[egsd_pkg::RAW_BITS-1:0];

   // The raw code is the code number plus one, so the signed mapping
   // halves it directly and odd raw codes are the negative ones.
   assign half      = {2'b00, raw[egsd_pkg::RAW_BITS-1:1]};
   assign cbp_hit   = (raw <= egsd_pkg::RAW_BITS'(egsd_pkg::CBP_ENTRIES));
   assign cbp_index = raw[5:0] - 6'd1;

   always_comb begin
      value_in  = '0;
      status_in = q_ctl.status;
      case (q_ctl.kind)
         egsd_pkg::KIND_UE: begin
            value_in = {1'b0, raw} - egsd_pkg::VALUE_BITS'(1);
         end
         egsd_pkg::KIND_SE: begin
            value_in = raw[0] ? (~half + egsd_pkg::VALUE_BITS'(1)) : half;
         end
         egsd_pkg::KIND_FIXED: begin
            value_in = {1'b0, raw};
         end
         egsd_pkg::KIND_ME: begin
            if (cbp_hit) begin
               value_in = egsd_pkg::VALUE_BITS'(egsd_pkg::CBP_INTRA_MAP[cbp_index]);
            end else begin
               status_in = egsd_pkg::STATUS_BAD_INDEX;
            end
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   assign q_ready = !valid_ff || rsp_if.ready;
   assign load    = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_ready) begin
         valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff  <= value_in;
         used_ff   <= q_ctl.bits_used;
         status_ff <= status_in;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.element_value = value_ff;
   assign rsp_if.bits_used     = used_ff;
   assign rsp_if.status        = status_ff;

endmodule

FILE: design/exp_golomb_syntax_decoder.sv
// ----------------------------------------------------------------------------
// exp_golomb_syntax_decoder: Exp-Golomb and fixed-length syntax element decoder
// Decodes one ue, se, u(n), peek or intra cbp me element per request word.
// ----------------------------------------------------------------------------
// Usage:
// The request channel takes a word with the element kind, a field length
// for fixed reads and the next WINDOW_BITS stream bits, most significant
// bit first. For every request word the response channel returns one word
// with the decoded value, the number of bits consumed and a status. The
// caller advances its stream position by bits_used before the next request.
// An accepted request is written into the queue, then into the output
// register, which drives the response channel. Throughput is one word per
// cycle while the receiver takes every word; the front end classifies a
// request in its accept cycle and the back end extracts and maps it as it
// leaves the queue, with a two-entry queue between them. When the receiver
// stalls, the output register holds its word, the queue fills and the
// request ready drops after two more words. Reset empties the queue and the
// output register; the decoder has no other state.
// ----------------------------------------------------------------------------
module exp_golomb_syntax_decoder #(
   parameter int WINDOW_BITS    = 64,
   parameter int MAX_FIXED_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   egsd_req_if.sink    req_if,
   egsd_rsp_if.source  rsp_if
);

   localparam int CTL_BITS   = $bits(egsd_pkg::ctl_type);
   localparam int QUEUE_BITS = CTL_BITS + WINDOW_BITS;

   logic                   f_valid, f_ready;
   egsd_pkg::ctl_type      f_ctl;
   logic [WINDOW_BITS-1:0] f_window;

   logic                   b_valid, b_ready;
   logic [QUEUE_BITS-1:0]  b_data;
   egsd_pkg::ctl_type      b_ctl;
   logic [WINDOW_BITS-1:0] b_window;

   egsd_front #(
      .WINDOW_BITS    (WINDOW_BITS),
      .MAX_FIXED_BITS (MAX_FIXED_BITS)
   ) u_front (
      .req_if   (req_if),
      .q_ready  (f_ready),
      .q_valid  (f_valid),
      .q_ctl    (f_ctl),
      .q_window (f_window)
   );

   egsd_queue #(
      .WIDTH (QUEUE_BITS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_ctl, f_window}),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_data  (b_data)
   );

   assign b_ctl    = egsd_pkg::ctl_type'(b_data[QUEUE_BITS-1 -: CTL_BITS]);
   assign b_window = b_data[WINDOW_BITS-1:0];

   egsd_back #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (b_valid),
      .q_ready  (b_ready),
      .q_ctl    (b_ctl),
      .q_window (b_window),
      .rsp_if   (rsp_if)
   );

endmodule

FILE: test/egsd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// egsd_checker: element predictor and response checker for the decoder
// Watches the request and response channels, decodes every accepted request
// word on its own and compares each accepted response word, in order, with
// the oldest decoded element still outstanding.
// ----------------------------------------------------------------------------
module egsd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_func,
   input  logic [5:0]        req_field_length,
   input  logic [63:0]       req_stream_window,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [32:0]       rsp_element_value,
   input  logic [5:0]        rsp_bits_used,
   input  logic [1:0]        rsp_status,
   output int                mismatch_count,
   output int                pending_count
);

   localparam int FIXED_LIMIT = 32;
   localparam int PREFIX_LIMIT = 32;
   localparam int INTRA_ENTRIES = 48;

   localparam logic [5:0] EXPECTED_CBP_MAP [INTRA_ENTRIES] = '{
      6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
      6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
      6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
      6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
      6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
   };

   typedef struct packed {
      logic [2:0]           func;
      logic [5:0]           field_length;
      logic [63:0]          window;
      logic [32:0]          value;
      logic [5:0]           used;
      egsd_pkg::status_type status;
   } element_type;

   element_type expected_elements[$];
   int          errors = 0;

   function automatic element_type decode_element(input logic [2:0] func,
                                                  input logic [5:0] field_length,
                                                  input logic [63:0] window);
      element_type e;
      int          zeros;
      int          code_len;
      int          n;
      logic [63:0] code;
      logic [63:0] signed_value;
      e.func = func;
      e.field_length = field_length;
      e.window = window;
      e.value = '0;
      e.used = '0;
      e.status = egsd_pkg::STATUS_OK;
      n = (field_length > FIXED_LIMIT) ? FIXED_LIMIT : int'(field_length);
      case (func)
         egsd_pkg::FUNC_UE, egsd_pkg::FUNC_SE, egsd_pkg::FUNC_ME: begin
            zeros = 0;
            while (zeros < PREFIX_LIMIT && window[63 - zeros] == 1'b0)
               zeros++;
            if (zeros == PREFIX_LIMIT) begin
               e.status = egsd_pkg::STATUS_LONG_PREFIX;
            end else begin
               code_len = 2 * zeros + 1;
               code = (window >> (64 - code_len)) - 64'd1;
               e.used = code_len[5:0];
               if (func == egsd_pkg::FUNC_UE) begin
                  e.value = code[32:0];
               end else if (func == egsd_pkg::FUNC_SE) begin
                  // Odd code numbers map to positive values.
                  if (code[0])
                     signed_value = (code + 64'd1) >> 1;
                  else
                     signed_value = 64'd0 - (code >> 1);
                  e.value = signed_value[32:0];
               end else if (code < INTRA_ENTRIES) begin
                  e.value = {27'd0, EXPECTED_CBP_MAP[code[5:0]]};
               end else begin
                  e.status = egsd_pkg::STATUS_BAD_INDEX;
               end
            end
         end
         egsd_pkg::FUNC_FIXED, egsd_pkg::FUNC_PEEK: begin
            if (n != 0)
               e.value = 33'(window >> (64 - n));
            if (func == egsd_pkg::FUNC_FIXED)
               e.used = n[5:0];
         end
         default: begin
         end
      endcase
      return e;
   endfunction

   always @(posedge clock) begin
      element_type want;
      if (!reset) begin
         // The response at this edge belongs to an older request, so it is
         // checked before this edge's request is added.
         if (rsp_valid && rsp_ready) begin
            if (expected_elements.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: extra response word: value %h used %0d status %0d",
                           $realtime, rsp_element_value, rsp_bits_used, rsp_status);
            end else begin
               want = expected_elements.pop_front();
               if (rsp_element_value !== want.value || rsp_bits_used !== want.used ||
                   rsp_status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: func %0d len %0d win %h: exp %h/%0d/%0d got %h/%0d/%0d",
                              $realtime, want.func, want.field_length, want.window,
                              want.value, want.used, want.status,
                              rsp_element_value, rsp_bits_used, rsp_status);
               end
            end
         end
         if (req_valid && req_ready)
            expected_elements.push_back(decode_element(req_func, req_field_length,
                                                       req_stream_window));
      end
      mismatch_count <= errors;
      pending_count <= expected_elements.size();
   end

endmodule

FILE: test/exp_golomb_syntax_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exp_golomb_syntax_decoder_tb: top level of the syntax decoder testbench
// Drives directed corner words and then random bursts of Exp-Golomb, fixed-length
// and noise requests, with a stalling receiver; the checker beside the
// decoder predicts every element and the top reports the verdict.
// ----------------------------------------------------------------------------
module exp_golomb_syntax_decoder_tb;

   localparam int RANDOM_ITEMS = 1330;

   logic        clock = 1'b0;
   logic        reset;
   int          mismatch_count;
   int          pending_count;
   logic [31:0] stall_pattern = '1;
   logic [5:0]  pattern_age = '0;

   egsd_req_if #(.WINDOW_BITS(64)) req_bus ();
   egsd_rsp_if                     rsp_bus ();

   exp_golomb_syntax_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   egsd_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_bus.valid),
      .req_ready         (req_bus.ready),
      .req_func          (req_bus.func),
      .req_field_length  (req_bus.field_length),
      .req_stream_window (req_bus.stream_window),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_element_value (rsp_bus.element_value),
      .rsp_bits_used     (rsp_bus.bits_used),
      .rsp_status        (rsp_bus.status),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   always #4 clock = ~clock;

   // The receiver replays a rotating 32-bit ready pattern and swaps it whenever
   // the 6-bit age counter wraps, sometimes for one that never stalls.
   always @(posedge clock) begin
      if (pattern_age == 0)
         stall_pattern <= ($urandom_range(0, 3) == 0) ? '1 : $urandom;
      else
         stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
      pattern_age <= pattern_age + 6'd1;
      rsp_bus.ready <= stall_pattern[0];
   end

   // Random window with exactly the given number of leading zeros; 64 or more
   // gives an all-zero window.
   function automatic logic [63:0] golomb_window(input int zeros);
      logic [63:0] w;
      w = {$urandom, $urandom};
      for (int b = 0; b < zeros && b < 64; b++)
         w[63 - b] = 1'b0;
      if (zeros < 64)
         w[63 - zeros] = 1'b1;
      return w;
   endfunction

   // Holds the word on the channel until the decoder takes it.
   task automatic send_word(input logic [2:0] func, input logic [5:0] field_length,
                            input logic [63:0] window);
      req_bus.valid <= 1'b1;
      req_bus.func <= func;
      req_bus.field_length <= field_length;
      req_bus.stream_window <= window;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   initial begin
      int          burst_left;
      int          gap;
      int          pick;
      int          zeros;
      logic [2:0]  func;
      logic [5:0]  field_length;
      logic [63:0] window;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func <= egsd_pkg::FUNC_UE;
      req_bus.field_length <= '0;
      req_bus.stream_window <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Corner words: shortest and longest codes, prefix overflow, signed
      // extremes, the ends of the intra table and fixed-length saturation.
      send_word(egsd_pkg::FUNC_UE, 6'd0, 64'h8000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_UE, 6'd63, 64'h4000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_UE, 6'd0, 64'h0000_0001_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_UE, 6'd0, 64'h0000_0000_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_UE, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_SE, 6'd0, 64'h4000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_SE, 6'd0, 64'h6000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_SE, 6'd0, 64'h0000_0001_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_SE, 6'd0, 64'h0000_0001_FFFF_FFFD);
      send_word(egsd_pkg::FUNC_SE, 6'd0, 64'h0000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_ME, 6'd0, 64'h8000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_ME, 6'd0, 64'h0600_0000_0000_0000);
      send_word(egsd_pkg::FUNC_ME, 6'd0, 64'h0620_0000_0000_0000);
      send_word(egsd_pkg::FUNC_ME, 6'd0, 64'h0000_0000_8000_0000);
      send_word(egsd_pkg::FUNC_FIXED, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_FIXED, 6'd1, 64'h8000_0000_0000_0000);
      send_word(egsd_pkg::FUNC_FIXED, 6'd32, 64'hFFFF_FFFF_0000_0000);
      send_word(egsd_pkg::FUNC_FIXED, 6'd33, 64'hA5A5_A5A5_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_FIXED, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_PEEK, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(egsd_pkg::FUNC_PEEK, 6'd32, 64'h1234_5678_9ABC_DEF0);
      send_word(egsd_pkg::FUNC_PEEK, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int k = egsd_pkg::FUNC_ME + 1; k < 8; k++)
         send_word(3'(k), 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);

      burst_left = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         field_length = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 32))
                                                   : 6'($urandom_range(33, 63));
         pick = $urandom_range(0, 99);
         if (pick < 92) begin
            if (pick < 22)
               func = egsd_pkg::FUNC_UE;
            else if (pick < 44)
               func = egsd_pkg::FUNC_SE;
            else if (pick < 62)
               func = egsd_pkg::FUNC_ME;
            else if (pick < 78)
               func = egsd_pkg::FUNC_FIXED;
            else
               func = egsd_pkg::FUNC_PEEK;
            pick = $urandom_range(0, 99);
            if (pick < 70)
               zeros = $urandom_range(0, (func == egsd_pkg::FUNC_ME) ? 6 : 8);
            else if (pick < 93)
               zeros = $urandom_range(9, 31);
            else
               zeros = $urandom_range(32, 64);
            window = golomb_window(zeros);
         end else begin
            // Noise: any kind code, including the unused ones.
            func = 3'($urandom_range(0, 7));
            window = {$urandom, $urandom};
         end
         send_word(func, field_length, window);
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
